@@ sv/text_cursor_glyph_emitter_assert.svh @@
// Assertion helpers for the text cursor glyph emitter RTL
`ifndef TEXT_CURSOR_GLYPH_EMITTER_ASSERT_SVH
`define TEXT_CURSOR_GLYPH_EMITTER_ASSERT_SVH

// clocked check, held off while reset is asserted
`define TCGE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds through reset
`define TCGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/tcge_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_pkg
// Types and constants shared by the text cursor glyph emitter.
// ----------------------------------------------------------------------------
package tcge_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_ON  = 3'd4;

    // character codes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_KANA_LO  = 8'hA0;
    localparam logic [7:0] CH_KANA_MID = 8'hBF;
    localparam logic [7:0] CH_KANA_HI  = 8'hDF;
    localparam logic [7:0] CH_GRAD_OFF = 8'h8A;
    localparam logic [7:0] CH_GRAD_ON  = 8'h8B;
    localparam logic [7:0] CH_KATAKANA = 8'h8C;
    localparam logic [7:0] CH_HIRAGANA = 8'h8D;
    localparam logic [7:0] KANA_SHIFT  = 8'h20;

    // geometry, quarter pixels
    localparam logic [15:0] CELL_W      = 16'd32;
    localparam logic [16:0] GLYPH_LO    = 17'd0;
    localparam logic [16:0] GLYPH_HI    = 17'd28;
    localparam logic [16:0] SHADOW_LO   = 17'd4;
    localparam logic [16:0] SHADOW_HI   = 17'd32;
    localparam logic [10:0] STEP_HIRES  = 11'd512;
    localparam logic [10:0] STEP_LORES  = 11'd1024;
    localparam logic [31:0] SHADOW_COLOR = 32'd0;

    // tab expansion limit
    localparam int TAB_SPACES_MAX = 8;
    localparam int TAB_CNT_W      = $clog2(TAB_SPACES_MAX + 1);

    // job queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        OP_PLACE,
        OP_SPACE,
        OP_NEWLINE,
        OP_CR,
        OP_DIRTY,
        OP_GLYPH,
        OP_TAB
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  code;
        logic [9:0]  col;
        logic [9:0]  row;
    } t_job;

    typedef enum logic [1:0] {
        CMD_REFRESH = 2'd0,
        CMD_COLOR   = 2'd1,
        CMD_RECT    = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [16:0] left;
        logic [16:0] top;
        logic [16:0] right;
        logic [16:0] bottom;
        logic [2:0]  tile;
        logic [8:0]  tex_s;
        logic [12:0] tex_t;
        logic [10:0] tex_step;
        logic [31:0] color;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [31:0] text_color;
        logic        high_res;
        logic        shadow_on;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REFRESH,
        S_SH_BLACK,
        S_SH_RECT,
        S_SH_COLOR,
        S_GLYPH
    } t_state;

endpackage
`default_nettype wire

@@ sv/tcge_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_front
// Accepts input words, tracks the kana set and turns each word it keeps into a job.
// ----------------------------------------------------------------------------
module tcge_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [9:0]    i_col_px,
    input  wire logic [9:0]    i_row_px,
    input  wire logic          i_full,
    output logic               o_push,
    output tcge_pkg::t_job     o_job
);
    import tcge_pkg::*;

    logic       r_hiragana;
    logic       n_hiragana;
    logic       accept;
    logic       keep;
    logic [7:0] kana;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && !i_full;

    // kana remap in hiragana mode
    always_comb begin
        kana = i_char_code;
        if (r_hiragana) begin
            kana = (i_char_code <= CH_KANA_MID) ? i_char_code - KANA_SHIFT
                                                : i_char_code + KANA_SHIFT;
        end
    end

    // classify the word
    always_comb begin
        keep       = 1'b1;
        n_hiragana = r_hiragana;
        o_job.op   = OP_PLACE;
        o_job.code = i_char_code;
        o_job.col  = i_col_px;
        o_job.row  = i_row_px;
        priority if (i_mode) begin
            o_job.op = OP_PLACE;
        end else if (i_char_code == CH_SPACE) begin
            o_job.op = OP_SPACE;
        end else if (i_char_code > CH_SPACE && i_char_code <= CH_PRINT_HI) begin
            o_job.op = OP_GLYPH;
        end else if (i_char_code >= CH_KANA_LO && i_char_code <= CH_KANA_HI) begin
            o_job.op   = OP_GLYPH;
            o_job.code = kana;
        end else if (i_char_code == CH_LF) begin
            o_job.op = OP_NEWLINE;
        end else if (i_char_code == CH_CR) begin
            o_job.op = OP_CR;
        end else if (i_char_code == CH_TAB) begin
            o_job.op = OP_TAB;
        end else if (i_char_code == CH_GRAD_ON || i_char_code == CH_GRAD_OFF) begin
            o_job.op = OP_DIRTY;
        end else if (i_char_code == CH_HIRAGANA) begin
            keep       = 1'b0;
            n_hiragana = 1'b1;
        end else if (i_char_code == CH_KATAKANA) begin
            keep       = 1'b0;
            n_hiragana = 1'b0;
        end else begin
            keep = 1'b0;
        end
    end

    assign o_push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hiragana <= 1'b0;
        end else if (accept) begin
            r_hiragana <= n_hiragana;
        end
    end

endmodule
`default_nettype wire

@@ sv/tcge_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tcge_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  tcge_pkg::t_job     i_job,
    input  wire logic          i_pop,
    output tcge_pkg::t_job     o_job,
    output logic               o_full,
    output logic               o_empty
);
    import tcge_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
        end
    end

endmodule
`default_nettype wire

@@ sv/tcge_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcge_back
// Runs jobs on cursor state, emits one command word per cycle unless stalled.
// ----------------------------------------------------------------------------
module tcge_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  tcge_pkg::t_cfg     i_cfg,
    input  tcge_pkg::t_job     i_job,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output tcge_pkg::t_cmd     o_cmd
);
    import tcge_pkg::*;

    `include "text_cursor_glyph_emitter_assert.svh"

    t_state               r_state, n_state;
    logic [15:0]          r_cx, n_cx;
    logic [15:0]          r_cy, n_cy;
    logic                 r_dirty, n_dirty;
    logic [7:0]           r_code, n_code;
    logic                 r_tab, n_tab;
    logic [TAB_CNT_W-1:0] r_k, n_k;
    logic                 r_out_valid;
    t_cmd                 r_out;
    t_cmd                 cmd;
    logic                 emit;
    logic                 slot_free;
    logic                 more;
    logic [15:0]          adv_cx;
    logic [7:0]           tab_off;
    logic [TAB_CNT_W-1:0] k_inc;
    t_state               glyph_start;

    // build a textured rectangle at the cursor
    function automatic t_cmd mk_rect(input logic [15:0] cx, input logic [15:0] cy,
                                     input logic [7:0] code, input logic hres,
                                     input logic [16:0] lo, input logic [16:0] hi);
        t_cmd        c;
        logic [16:0] l;
        logic [16:0] t;
        logic [16:0] r;
        logic [16:0] b;
        l = {1'b0, cx} + lo;
        t = {1'b0, cy} + lo;
        r = {1'b0, cx} + hi;
        b = {1'b0, cy} + hi;
        c          = '0;
        c.kind     = CMD_RECT;
        c.left     = hres ? {l[15:0], 1'b0} : l;
        c.top      = hres ? {t[15:0], 1'b0} : t;
        c.right    = hres ? {r[15:0], 1'b0} : r;
        c.bottom   = hres ? {b[15:0], 1'b0} : b;
        c.tile     = {code[1:0], 1'b0};
        c.tex_s    = {code[2], 8'd0};
        c.tex_t    = {code[7:3], 8'd0};
        c.tex_step = hres ? STEP_HIRES : STEP_LORES;
        return c;
    endfunction

    assign slot_free = !r_out_valid || i_out_ready;
    assign adv_cx    = r_cx + CELL_W;
    assign tab_off   = adv_cx[7:0] - i_cfg.origin_x[7:0];
    assign k_inc     = r_k + TAB_CNT_W'(1);
    assign more      = r_tab && (tab_off != 8'd0)
                       && (k_inc < TAB_CNT_W'(TAB_SPACES_MAX));
    assign glyph_start = i_cfg.shadow_on ? S_SH_BLACK : S_GLYPH;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_dirty = r_dirty;
        n_code  = r_code;
        n_tab   = r_tab;
        n_k     = r_k;
        o_pop   = 1'b0;
        emit    = 1'b0;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_job.op)
                        OP_PLACE: begin
                            n_cx = {4'd0, i_cfg.origin_x} + {4'd0, i_job.col, 2'b00};
                            n_cy = {4'd0, i_cfg.origin_y} + {4'd0, i_job.row, 2'b00};
                        end
                        OP_SPACE: begin
                            n_cx = adv_cx;
                        end
                        OP_NEWLINE: begin
                            n_cy = r_cy + CELL_W;
                            n_cx = {4'd0, i_cfg.origin_x};
                        end
                        OP_CR: begin
                            n_cx = {4'd0, i_cfg.origin_x};
                        end
                        OP_DIRTY: begin
                            n_dirty = 1'b1;
                        end
                        OP_GLYPH, OP_TAB: begin
                            n_tab   = (i_job.op == OP_TAB);
                            n_code  = (i_job.op == OP_TAB) ? CH_SPACE : i_job.code;
                            n_k     = '0;
                            n_state = r_dirty ? S_REFRESH : glyph_start;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_REFRESH: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    cmd.kind = CMD_REFRESH;
                    n_dirty  = 1'b0;
                    n_state  = glyph_start;
                end
            end
            S_SH_BLACK: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    cmd.kind  = CMD_COLOR;
                    cmd.color = SHADOW_COLOR;
                    n_state   = S_SH_RECT;
                end
            end
            S_SH_RECT: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    cmd     = mk_rect(r_cx, r_cy, r_code, i_cfg.high_res,
                                      SHADOW_LO, SHADOW_HI);
                    n_state = S_SH_COLOR;
                end
            end
            S_SH_COLOR: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    cmd.kind  = CMD_COLOR;
                    cmd.color = i_cfg.text_color;
                    n_state   = S_GLYPH;
                end
            end
            S_GLYPH: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    cmd      = mk_rect(r_cx, r_cy, r_code, i_cfg.high_res,
                                       GLYPH_LO, GLYPH_HI);
                    cmd.last = !more;
                    n_cx     = adv_cx;
                    if (more) begin
                        n_k     = k_inc;
                        n_state = glyph_start;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_dirty <= 1'b1;
            r_tab   <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_dirty <= n_dirty;
            r_tab   <= n_tab;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= cmd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = r_out;

    // checks
    `TCGE_ASSERT(a_pop_idle, i_clk, i_rst_n, o_pop |-> (r_state == S_IDLE), "pop outside idle")
    `TCGE_ASSERT(a_rect_black, i_clk, i_rst_n, (r_out_valid && r_out.kind == CMD_RECT) |-> (r_out.color == '0), "rectangle with colour")
    `TCGE_ASSERT(a_refresh_clears, i_clk, i_rst_n, (emit && r_state == S_REFRESH) |=> !r_dirty, "mode dirty left set")
    `TCGE_ASSERT(a_tab_bound, i_clk, i_rst_n, r_k < TAB_CNT_W'(TAB_SPACES_MAX), "tab count overrun")
    `TCGE_ASSERT_ALWAYS(a_no_emit_stalled, i_clk, emit |-> slot_free, "output overwritten")

endmodule
`default_nettype wire

@@ sv/text_cursor_glyph_emitter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_cursor_glyph_emitter
// Text overlay command generator: characters and cursor moves in, commands out.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one word: a character code or
// a cursor placement. Output channel (o_out_valid / i_out_ready) gives one
// command word per handshake; o_last marks the final command of an input.
// The configuration port writes a register whenever i_cfg_we is high.
// A glyph yields one to five commands (refresh, shadow colour, shadow
// rectangle, colour restore, glyph rectangle), one per cycle while the
// receiver keeps up; the sequencer fetches each job in its idle state. A tab
// yields up to eight spaces of up to four commands each, plus one refresh.
// Words with no command retire in the idle state. An accepted input goes
// through the job queue, the sequencer state and the output register.
// A four-entry job queue lets input be taken while commands are pending.
// Reset clears the cursor, selects katakana and marks the mode dirty so the
// first glyph is preceded by a refresh; shadow is on after reset.
// When the receiver stalls, the output register holds its word, the
// sequencer waits, and input is accepted until the job queue fills.
// ----------------------------------------------------------------------------
module text_cursor_glyph_emitter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_mode,
    input  wire logic [7:0]    i_char_code,
    input  wire logic [9:0]    i_col_px,
    input  wire logic [9:0]    i_row_px,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_cmd_kind,
    output logic [16:0]        o_rect_left,
    output logic [16:0]        o_rect_top,
    output logic [16:0]        o_rect_right,
    output logic [16:0]        o_rect_bottom,
    output logic [2:0]         o_tile_index,
    output logic [8:0]         o_tex_s,
    output logic [12:0]        o_tex_t,
    output logic [10:0]        o_tex_step,
    output logic [31:0]        o_color_value,
    output logic               o_last,
    input  wire logic          i_cfg_we,
    input  wire logic [tcge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);
    import tcge_pkg::*;

    t_cfg r_cfg;
    t_job push_job;
    t_job head_job;
    t_cmd cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.text_color <= '0;
            r_cfg.high_res   <= 1'b0;
            r_cfg.shadow_on  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X:   r_cfg.origin_x   <= i_cfg_data[11:0];
                CFG_ORIGIN_Y:   r_cfg.origin_y   <= i_cfg_data[11:0];
                CFG_TEXT_COLOR: r_cfg.text_color <= i_cfg_data;
                CFG_HIGH_RES:   r_cfg.high_res   <= i_cfg_data[0];
                CFG_SHADOW_ON:  r_cfg.shadow_on  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    tcge_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_col_px    (i_col_px),
        .i_row_px    (i_row_px),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    tcge_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    tcge_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (head_job),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // command word onto ports
    assign o_cmd_kind    = cmd.kind;
    assign o_rect_left   = cmd.left;
    assign o_rect_top    = cmd.top;
    assign o_rect_right  = cmd.right;
    assign o_rect_bottom = cmd.bottom;
    assign o_tile_index  = cmd.tile;
    assign o_tex_s       = cmd.tex_s;
    assign o_tex_t       = cmd.tex_t;
    assign o_tex_step    = cmd.tex_step;
    assign o_color_value = cmd.color;
    assign o_last        = cmd.last;

endmodule
`default_nettype wire
